@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL in this folder.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is low.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/gsds_pkg.sv @@
// Shared types and constants for the GPS speed display smoother.
// No dependencies; imported by gsds_kmh_conv and gps_speed_display_smoother.
`timescale 1ns / 1ps

package gsds_pkg;

   localparam int unsigned SPEED_W    = 22;
   localparam int unsigned KMH_W      = 8;
   localparam int unsigned OP_W       = 2;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned DASH_W     = 2;
   localparam int unsigned BRIGHT_W   = 3;
   localparam int unsigned BCODE_W    = 4;
   localparam int unsigned HOLD_W     = 4;
   localparam int unsigned NOFIX_W    = 4;
   localparam int unsigned DIDX_W     = 3;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 8;

   // km/h = mm/s * 9 / 2500
   localparam int unsigned SCALED_W    = SPEED_W + 4;
   localparam int unsigned KMH_STEP    = 2500;
   localparam int unsigned SAT_SCALED  = 255 * KMH_STEP;
   // below saturation the scaled speed fits 20 bits
   localparam int unsigned QUOT_IN_W   = 20;
   // ceil(2^32 / 2500): exact floor division for inputs below 2^20
   localparam int unsigned RECIP_SHIFT = 32;
   localparam longint unsigned RECIP   = 64'd1717987;
   localparam int unsigned RECIP_W     = 21;
   localparam int unsigned PROD_W      = QUOT_IN_W + RECIP_W;

   localparam logic [OP_W-1:0] OP_GPS    = 2'd0;
   localparam logic [OP_W-1:0] OP_POWER  = 2'd1;
   localparam logic [OP_W-1:0] OP_BRIGHT = 2'd2;

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE   = 2'd0,
      KIND_NUMBER = 2'd1,
      KIND_DASH   = 2'd2
   } update_kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_STOP_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_LIMIT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOFIX_INTERVAL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DASH_POSITIONS = 2'd3;

   localparam logic [BCODE_W-1:0] BRIGHT_OFF  = 4'd8;
   localparam logic [BCODE_W-1:0] BRIGHT_FULL = 4'd7;
   localparam logic [BCODE_W-1:0] BRIGHT_WRAP = 4'd6;

   localparam logic [KMH_W-1:0] KMH_MAX = 8'd255;

endpackage

@@ rtl/core/gps_speed_display_smoother.sv @@
// GPS speed display smoother. One display command comes out for every beat in:
// a GPS message, an on/off press or a brightness press. The block takes a beat
// every cycle while the result side is not stalled; each beat's result passes
// through the input register, speed conversion register and result register.
// A stalled result stalls the whole pipe, so req_stall follows rsp_stall while a
// result is waiting. Configuration registers are written through the csr_ port
// and take effect on the next beat.
// Depends on gsds_pkg, gsds_kmh_conv and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gps_speed_display_smoother import gsds_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_op,
   input  logic                  req_fix_valid,
   input  logic [SPEED_W-1:0]    req_ground_speed_mm_s,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KIND_W-1:0]     rsp_update_kind,
   output logic [KMH_W-1:0]      rsp_shown_number,
   output logic [DASH_W-1:0]     rsp_dash_position,
   output logic [BRIGHT_W-1:0]   rsp_brightness_level,
   output logic                  rsp_display_on,

   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [KMH_W-1:0]   stop_threshold_ff;
   logic [HOLD_W-1:0]  hold_limit_ff;
   logic [NOFIX_W-1:0] nofix_interval_ff;
   logic [DIDX_W-1:0]  dash_positions_ff;

   // pipe control
   logic advance;
   logic a_valid_ff;
   logic b_valid_ff;
   logic rsp_valid_ff;

   // stage A: input register
   logic [OP_W-1:0]    a_op_ff;
   logic               a_fix_ff;
   logic [SPEED_W-1:0] a_speed_ff;
   logic [KMH_W-1:0]   a_kmh;

   // stage B: converted speed
   logic [OP_W-1:0]    b_op_ff;
   logic               b_fix_ff;
   logic [KMH_W-1:0]   b_kmh_ff;

   // display state
   logic [KMH_W-1:0]   last_speed_ff,  last_speed_in;
   logic [HOLD_W-1:0]  hold_count_ff,  hold_count_in;
   logic [KMH_W-1:0]   shown_speed_ff, shown_speed_in;
   logic [NOFIX_W-1:0] nofix_count_ff, nofix_count_in;
   logic [DIDX_W-1:0]  dash_index_ff,  dash_index_in;
   logic [BCODE_W-1:0] bright_code_ff, bright_code_in;

   // result
   update_kind_type    kind_in;
   logic [KMH_W-1:0]   number_in;
   logic [DASH_W-1:0]  pos_in;
   logic [DIDX_W-1:0]  dash_sel;
   logic               one_step;
   logic               release_hold;
   logic [KIND_W-1:0]  kind_ff;
   logic [KMH_W-1:0]   number_ff;
   logic [DASH_W-1:0]  pos_ff;
   logic [BCODE_W-1:0] rsp_code_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_threshold_ff <= 8'd4;
         hold_limit_ff     <= 4'd10;
         nofix_interval_ff <= 4'd10;
         dash_positions_ff <= 3'd4;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STOP_THRESHOLD: stop_threshold_ff <= csr_wdata;
            CSR_HOLD_LIMIT:     hold_limit_ff     <= csr_wdata[HOLD_W-1:0];
            CSR_NOFIX_INTERVAL: nofix_interval_ff <= csr_wdata[NOFIX_W-1:0];
            CSR_DASH_POSITIONS: dash_positions_ff <= csr_wdata[DIDX_W-1:0];
         endcase
      end
   end

   gsds_kmh_conv u_kmh_conv (
      .ground_speed   (a_speed_ff),
      .stop_threshold (stop_threshold_ff),
      .kmh            (a_kmh)
   );

   // speed smoothing and no-fix dash; only a change of exactly one is held
   assign one_step     = ({1'b0, last_speed_ff} + 9'd1 == {1'b0, b_kmh_ff}) ||
                         ({1'b0, b_kmh_ff} + 9'd1 == {1'b0, last_speed_ff});
   // hold_count > hold_limit - 2, signed, without the subtraction
   assign release_hold = ({2'b00, hold_count_ff} + 6'd2) > {2'b00, hold_limit_ff};
   assign dash_sel     = (dash_index_ff == dash_positions_ff) ? '0 : dash_index_ff;

   always_comb begin
      last_speed_in  = last_speed_ff;
      hold_count_in  = hold_count_ff;
      shown_speed_in = shown_speed_ff;
      nofix_count_in = nofix_count_ff;
      dash_index_in  = dash_index_ff;
      bright_code_in = bright_code_ff;
      kind_in        = KIND_NONE;
      number_in      = '0;
      pos_in         = '0;

      unique case (b_op_ff)
         OP_GPS: begin
            if (b_fix_ff) begin
               nofix_count_in = '0;
               dash_index_in  = '0;
               if (one_step && !release_hold) begin
                  hold_count_in  = hold_count_ff + HOLD_W'(1);
                  shown_speed_in = last_speed_ff;
               end else begin
                  hold_count_in  = '0;
                  last_speed_in  = b_kmh_ff;
                  shown_speed_in = b_kmh_ff;
               end
               kind_in   = KIND_NUMBER;
               number_in = shown_speed_in;
            end else if (nofix_count_ff == nofix_interval_ff) begin
               nofix_count_in = NOFIX_W'(1);
               kind_in        = KIND_DASH;
               pos_in         = dash_sel[DASH_W-1:0];
               dash_index_in  = dash_sel + DIDX_W'(1);
            end else begin
               nofix_count_in = nofix_count_ff + NOFIX_W'(1);
            end
         end
         OP_POWER: begin
            bright_code_in = (bright_code_ff == BRIGHT_OFF) ? BRIGHT_FULL : BRIGHT_OFF;
            kind_in        = KIND_NUMBER;
            number_in      = shown_speed_ff;
         end
         OP_BRIGHT: begin
            bright_code_in = (bright_code_ff >= BRIGHT_WRAP) ? '0
                                                             : bright_code_ff + BCODE_W'(1);
            kind_in        = KIND_NUMBER;
            number_in      = shown_speed_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         last_speed_ff  <= '0;
         hold_count_ff  <= '0;
         shown_speed_ff <= '0;
         nofix_count_ff <= '0;
         dash_index_ff  <= '0;
         bright_code_ff <= BRIGHT_FULL;
      end else if (advance) begin
         a_valid_ff   <= req_valid;
         b_valid_ff   <= a_valid_ff;
         rsp_valid_ff <= b_valid_ff;
         if (b_valid_ff) begin
            last_speed_ff  <= last_speed_in;
            hold_count_ff  <= hold_count_in;
            shown_speed_ff <= shown_speed_in;
            nofix_count_ff <= nofix_count_in;
            dash_index_ff  <= dash_index_in;
            bright_code_ff <= bright_code_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_op_ff     <= req_op;
         a_fix_ff    <= req_fix_valid;
         a_speed_ff  <= req_ground_speed_mm_s;
         b_op_ff     <= a_op_ff;
         b_fix_ff    <= a_fix_ff;
         b_kmh_ff    <= a_kmh;
         kind_ff     <= kind_in;
         number_ff   <= number_in;
         pos_ff      <= pos_in;
         rsp_code_ff <= bright_code_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_update_kind      = kind_ff;
   assign rsp_shown_number     = number_ff;
   assign rsp_dash_position    = pos_ff;
   assign rsp_brightness_level = (rsp_code_ff == BRIGHT_OFF) ? '0 : rsp_code_ff[BRIGHT_W-1:0];
   assign rsp_display_on       = (rsp_code_ff != BRIGHT_OFF);

   // a beat leaving stage B always lands in the result register
   `ASSERT_CLK_RST(a_stage_b_to_rsp, clock, reset, (b_valid_ff && advance) |=> rsp_valid_ff, "stage B beat lost")
   // the shown speed always tracks the smoothing reference
   `ASSERT_CLK_RST(a_shown_tracks_last, clock, reset, shown_speed_ff == last_speed_ff, "shown speed diverged from last speed")
   // a dash result restarts the no-fix counter
   `ASSERT_CLK_RST(a_dash_restarts_count, clock, reset, (rsp_valid_ff && kind_ff == KIND_DASH) |-> (nofix_count_ff == NOFIX_W'(1)), "no-fix counter not restarted")
   // brightness code stays within the off code
   `ASSERT_CLK_RST(a_bright_code_range, clock, reset, bright_code_ff <= BRIGHT_OFF, "brightness code out of range")

endmodule

@@ rtl/core/gsds_kmh_conv.sv @@
// Ground speed (mm/s) to displayed km/h with stop threshold and saturation.
// Depends on gsds_pkg.
`timescale 1ns / 1ps

module gsds_kmh_conv import gsds_pkg::*; (
   input  logic [SPEED_W-1:0] ground_speed,
   input  logic [KMH_W-1:0]   stop_threshold,
   output logic [KMH_W-1:0]   kmh
);

   logic [SCALED_W-1:0]  scaled;
   logic [SCALED_W-1:0]  stop_limit;
   logic [QUOT_IN_W-1:0] scaled_lo;
   logic [PROD_W-1:0]    product;
   logic [KMH_W-1:0]     quotient;

   assign scaled     = {1'b0, ground_speed, 3'b000} + {4'b0000, ground_speed};
   assign stop_limit = SCALED_W'(stop_threshold) * SCALED_W'(KMH_STEP);
   assign scaled_lo  = scaled[QUOT_IN_W-1:0];
   // floor(scaled / 2500) by reciprocal; only used below saturation
   assign product    = PROD_W'(scaled_lo) * PROD_W'(RECIP);
   assign quotient   = product[RECIP_SHIFT +: KMH_W];

   always_comb begin
      priority if (scaled < stop_limit) begin
         kmh = '0;
      end else if (scaled >= SCALED_W'(SAT_SCALED)) begin
         kmh = KMH_MAX;
      end else begin
         kmh = quotient + KMH_W'(1);
      end
   end

endmodule
